FILE: sv/i2cra_pkg.sv
// Types, constants and helper functions for the I2C register-access master.
// No dependencies; imported by i2c_master_register_access.
package i2cra_pkg;

    // Configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_STEP_TICKS     = 1'b1;

    // Transaction opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_PROBE = 2'd3;

    // Segment kinds of a transaction script
    typedef enum logic [3:0] {
        K_START  = 4'd0,
        K_ADDR_W = 4'd1,
        K_ADDR_R = 4'd2,
        K_REG    = 4'd3,
        K_DATA   = 4'd4,
        K_ACK    = 4'd5,
        K_RECV   = 4'd6,
        K_NACK   = 4'd7,
        K_STOP   = 4'd8
    } t_kind;

    // Number of segments in the script of an opcode
    function automatic logic [3:0] script_len(input logic [1:0] op);
        logic [3:0] len;
        unique case (op)
            OP_TICK:  len = 4'd0;
            OP_WRITE: len = 4'd8;
            OP_READ:  len = 4'd11;
            OP_PROBE: len = 4'd4;
        endcase
        return len;
    endfunction

    // Segment kind at script position pos (1-based)
    function automatic t_kind script_kind(input logic [1:0] op, input logic [3:0] pos);
        t_kind k;
        k = K_START;
        unique case (op)
            OP_WRITE: begin
                case (pos)
                    4'd1:    k = K_START;
                    4'd2:    k = K_ADDR_W;
                    4'd3:    k = K_ACK;
                    4'd4:    k = K_REG;
                    4'd5:    k = K_ACK;
                    4'd6:    k = K_DATA;
                    4'd7:    k = K_ACK;
                    4'd8:    k = K_STOP;
                    default: k = K_START;
                endcase
            end
            OP_READ: begin
                case (pos)
                    4'd1:    k = K_START;
                    4'd2:    k = K_ADDR_W;
                    4'd3:    k = K_ACK;
                    4'd4:    k = K_REG;
                    4'd5:    k = K_ACK;
                    4'd6:    k = K_START;
                    4'd7:    k = K_ADDR_R;
                    4'd8:    k = K_ACK;
                    4'd9:    k = K_RECV;
                    4'd10:   k = K_NACK;
                    4'd11:   k = K_STOP;
                    default: k = K_START;
                endcase
            end
            OP_PROBE: begin
                case (pos)
                    4'd1:    k = K_START;
                    4'd2:    k = K_ADDR_W;
                    4'd3:    k = K_ACK;
                    4'd4:    k = K_STOP;
                    default: k = K_START;
                endcase
            end
            OP_TICK: k = K_START;
        endcase
        return k;
    endfunction

    // Line levels {scl, sda} after applying sub-step sub of a segment
    function automatic logic [1:0] line_step(input t_kind kind, input logic [1:0] sub,
                                             input logic msb, input logic [1:0] lines);
        logic scl;
        logic sda;
        scl = lines[1];
        sda = lines[0];
        case (kind)
            K_START: begin
                unique case (sub)
                    2'd0: sda = 1'b1;
                    2'd1: scl = 1'b1;
                    2'd2: sda = 1'b0;
                    2'd3: scl = 1'b0;
                endcase
            end
            K_ADDR_W, K_ADDR_R, K_REG, K_DATA: begin
                if (sub == 2'd0) begin
                    sda = msb;
                end else if (sub == 2'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
            K_STOP: begin
                if (sub == 2'd0) begin
                    sda = 1'b0;
                end else if (sub == 2'd1) begin
                    scl = 1'b1;
                end else begin
                    sda = 1'b1;
                end
            end
            default: begin // ack slot, receive, nack
                if (sub == 2'd0) begin
                    sda = 1'b1;
                end else if (sub == 2'd1) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
        endcase
        return {scl, sda};
    endfunction

endpackage

FILE: sv/i2c_master_register_access.sv
// I2C master for register write, register read and address probe transactions.
// Depends on i2cra_pkg (segment kinds, scripts, line-step function).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------------
//  in      | in        | i_in_valid / o_in_stall   | opcode, reg_address, write_data, sda_in
//  out     | out       | o_out_valid / i_out_stall | scl_out, sda_out, busy_res, done_res,
//          |           |                           | read_byte, nack
//  cfg     | in        | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// Each input transaction is one bus tick and yields exactly one result transaction.
// One tick is taken per clock cycle while the input is not stalled; the sequencer state
// and the result register update in the same cycle. Bus timing is set only by the
// step counter: each line step lasts step_ticks accepted ticks (zero counts as one).
// Reset (synchronous, active low) returns to idle with both lines released.
// The input is stalled only while a result is held and the output side stalls.
module i2c_master_register_access
    import i2cra_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_reg_address,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_byte,
    output logic       o_nack,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Compare width: wide enough for both the step setting and the counter
    localparam int CMP_W = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    // Configuration
    logic [6:0]  r_dev_addr;
    logic [15:0] r_step_ticks;

    // Sequencer state
    logic [3:0]                  r_pos,   n_pos;   // script position, 0 = idle
    logic [1:0]                  r_sub,   n_sub;   // sub-step within segment
    logic [2:0]                  r_bit,   n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic [TICK_COUNT_WIDTH-1:0] r_tick,  n_tick;
    logic [1:0]                  r_op,    n_op;
    logic [7:0]                  r_reg,   n_reg;
    logic [7:0]                  r_data,  n_data;
    logic [7:0]                  r_rx,    n_rx;
    logic                        r_nack,  n_nack;
    logic [1:0]                  r_lines, n_lines; // {scl, sda}

    // Result register
    logic       r_out_valid;
    logic       r_scl, r_sda, r_busy, r_done, r_nack_o;
    logic [7:0] r_rx_o;

    logic in_acc;
    logic busy, done;

    // Step limit: zero counts as one, saturate to the counter range
    logic [CMP_W-1:0]            step_e, mask_e, limit;
    logic [TICK_COUNT_WIDTH-1:0] tick_inc;

    // Segment decode
    t_kind      kind, ent_kind;
    logic [3:0] len;
    logic [4:0] pos_next;
    logic [1:0] next_sub;
    logic       last;
    logic       do_enter;
    logic       do_finish;
    logic [3:0] ent_pos;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_acc      = i_in_valid & ~o_in_stall;

    assign step_e   = CMP_W'(r_step_ticks);
    assign mask_e   = CMP_W'({TICK_COUNT_WIDTH{1'b1}});
    assign limit    = (step_e == '0) ? CMP_W'(1) : ((step_e > mask_e) ? mask_e : step_e);
    assign tick_inc = r_tick + TICK_COUNT_WIDTH'(1);

    assign len      = script_len(r_op);
    assign kind     = script_kind(r_op, r_pos);
    assign pos_next = {1'b0, r_pos} + 5'd1;

    always_comb begin
        n_pos     = r_pos;
        n_sub     = r_sub;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_tick    = r_tick;
        n_op      = r_op;
        n_reg     = r_reg;
        n_data    = r_data;
        n_rx      = r_rx;
        n_nack    = r_nack;
        n_lines   = r_lines;
        busy      = 1'b0;
        done      = 1'b0;
        do_enter  = 1'b0;
        do_finish = 1'b0;
        ent_pos   = 4'd1;
        next_sub  = r_sub + 2'd1;
        last      = 1'b0;
        ent_kind  = K_START;

        if (r_pos == 4'd0) begin
            // idle: a non-zero opcode starts a transaction on this tick
            if (i_opcode != OP_TICK) begin
                n_op     = i_opcode;
                n_reg    = i_reg_address;
                n_data   = i_write_data;
                n_nack   = 1'b0;
                n_tick   = '0;
                do_enter = 1'b1;
                ent_pos  = 4'd1;
                busy     = 1'b1;
            end
        end else begin
            n_tick = tick_inc;
            if (CMP_W'(tick_inc) >= limit) begin
                n_tick = '0;
                if (r_pos > len) begin
                    do_finish = 1'b1;
                end else begin
                    // sample at the end of an SCL-high step
                    if (r_sub == 2'd1 && kind == K_ACK && i_sda_in) begin
                        n_nack = 1'b1;
                    end
                    if (r_sub == 2'd1 && kind == K_RECV) begin
                        n_shift = {r_shift[6:0], i_sda_in};
                    end
                    case (kind)
                        K_START: last = (r_sub == 2'd3);
                        K_ADDR_W, K_ADDR_R, K_REG, K_DATA: begin
                            if (r_sub >= 2'd2) begin
                                if (r_bit == 3'd7) begin
                                    last = 1'b1;
                                end else begin
                                    n_bit    = r_bit + 3'd1;
                                    n_shift  = {r_shift[6:0], 1'b0};
                                    next_sub = 2'd0;
                                end
                            end
                        end
                        K_RECV: begin
                            if (r_sub >= 2'd2) begin
                                if (r_bit == 3'd7) begin
                                    last = 1'b1;
                                end else begin
                                    n_bit    = r_bit + 3'd1;
                                    next_sub = 2'd1;
                                end
                            end
                        end
                        default: last = (r_sub >= 2'd2);
                    endcase

                    if (!last) begin
                        n_sub   = next_sub;
                        n_lines = line_step(kind, next_sub, n_shift[7], r_lines);
                    end else begin
                        if (kind == K_RECV) begin
                            n_rx = n_shift;
                        end
                        if (pos_next > {1'b0, len}) begin
                            do_finish = 1'b1;
                        end else begin
                            do_enter = 1'b1;
                            ent_pos  = pos_next[3:0];
                        end
                    end
                end
            end
            busy = ~do_finish;
            done = do_finish;
        end

        // segment entry: load the byte to shift and apply its first step
        if (do_enter) begin
            ent_kind = script_kind(n_op, ent_pos);
            n_bit    = 3'd0;
            case (ent_kind)
                K_ADDR_W: n_shift = {r_dev_addr, 1'b0};
                K_ADDR_R: n_shift = {r_dev_addr, 1'b1};
                K_REG:    n_shift = n_reg;
                K_DATA:   n_shift = n_data;
                K_RECV:   n_shift = 8'h00;
                default:  ;
            endcase
            n_pos   = ent_pos;
            n_sub   = 2'd0;
            n_lines = line_step(ent_kind, 2'd0, n_shift[7], n_lines);
        end

        if (do_finish) begin
            n_pos   = 4'd0;
            n_sub   = 2'd0;
            n_bit   = 3'd0;
            n_lines = 2'b11;
        end
    end

    // configuration, sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr   <= 7'd0;
            r_step_ticks <= 16'd10;
            r_pos        <= 4'd0;
            r_sub        <= 2'd0;
            r_bit        <= 3'd0;
            r_shift      <= 8'd0;
            r_tick       <= '0;
            r_op         <= OP_TICK;
            r_reg        <= 8'd0;
            r_data       <= 8'd0;
            r_rx         <= 8'd0;
            r_nack       <= 1'b0;
            r_lines      <= 2'b11;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DEVICE_ADDRESS: r_dev_addr   <= i_cfg_data[6:0];
                    CFG_STEP_TICKS:     r_step_ticks <= i_cfg_data;
                endcase
            end
            if (in_acc) begin
                r_pos       <= n_pos;
                r_sub       <= n_sub;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_op        <= n_op;
                r_reg       <= n_reg;
                r_data      <= n_data;
                r_rx        <= n_rx;
                r_nack      <= n_nack;
                r_lines     <= n_lines;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_scl    <= n_lines[1];
            r_sda    <= n_lines[0];
            r_busy   <= busy;
            r_done   <= done;
            r_rx_o   <= n_rx;
            r_nack_o <= n_nack;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_scl;
    assign o_sda_out   = r_sda;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_read_byte = r_rx_o;
    assign o_nack      = r_nack_o;

endmodule

FILE: tb/sv/tb_i2c_master_register_access.sv
// Self-checking testbench for the I2C register-access master: drives bus ticks,
// predicts every result transaction and compares them field by field.
// Depends on i2cra_pkg (opcodes, register indexes, segment kinds) and the DUT.
`timescale 1ns / 1ps

module tb_i2c_master_register_access
    import i2cra_pkg::*;
();

    // sda_in patterns for whole transfers
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    // output hold-off used to back the block up into its input
    localparam int HOLD_CYCLES = 64;

    // segment scripts of the three bus operations
    localparam t_kind WRITE_SEGS [8] = '{K_START, K_ADDR_W, K_ACK, K_REG, K_ACK, K_DATA,
                                        K_ACK, K_STOP};
    localparam t_kind READ_SEGS [11] = '{K_START, K_ADDR_W, K_ACK, K_REG, K_ACK, K_START,
                                        K_ADDR_R, K_ACK, K_RECV, K_NACK, K_STOP};
    localparam t_kind PROBE_SEGS [4] = '{K_START, K_ADDR_W, K_ACK, K_STOP};

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rd_byte;
        logic       nack;
    } t_bus_sample;

    // Tracks the bus sequencer tick by tick and holds the line samples it should produce.
    class bus_tick_scoreboard;
        logic [6:0]  dev_addr  = 7'd0;
        logic [15:0] step_len  = 16'd10;
        logic [5:0]  seq_step  = 6'd0;   // {segment position, sub-step}
        logic [2:0]  bit_idx   = 3'd0;
        logic [7:0]  shifter   = 8'd0;
        logic [15:0] tick_cnt  = 16'd0;
        logic [1:0]  cur_op    = OP_TICK;
        logic [7:0]  reg_byte  = 8'd0;
        logic [7:0]  data_byte = 8'd0;
        logic [7:0]  rx_byte   = 8'd0;
        logic        nack_seen = 1'b0;
        logic        scl       = 1'b1;
        logic        sda       = 1'b1;
        t_bus_sample expected_lines[$];
        int          errors    = 0;

        function int seg_count(logic [1:0] op);
            case (op)
                OP_WRITE: return 8;
                OP_READ:  return 11;
                OP_PROBE: return 4;
                default:  return 0;
            endcase
        endfunction

        function t_kind segment_kind(logic [1:0] op, logic [3:0] pos);
            case (op)
                OP_WRITE: return WRITE_SEGS[pos - 1];
                OP_READ:  return READ_SEGS[pos - 1];
                OP_PROBE: return PROBE_SEGS[pos - 1];
                default:  return K_START;
            endcase
        endfunction

        function void apply_cfg(logic idx, logic [15:0] val);
            if (idx == CFG_DEVICE_ADDRESS) begin
                dev_addr = val[6:0];
            end else begin
                step_len = val;
            end
        endfunction

        function bit bus_active();
            return seq_step != 6'd0;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        // line change made on entering sub-step sub of a segment
        function void drive_line(t_kind kind, logic [1:0] sub);
            case (kind)
                K_START: begin
                    case (sub)
                        2'd0:    sda = 1'b1;
                        2'd1:    scl = 1'b1;
                        2'd2:    sda = 1'b0;
                        default: scl = 1'b0;
                    endcase
                end
                K_ADDR_W, K_ADDR_R, K_REG, K_DATA: begin
                    if (sub == 2'd0) begin
                        sda = shifter[7];
                    end else begin
                        scl = (sub == 2'd1);
                    end
                end
                K_STOP: begin
                    if (sub == 2'd1) begin
                        scl = 1'b1;
                    end else begin
                        sda = (sub != 2'd0);
                    end
                end
                default: begin
                    if (sub == 2'd0) begin
                        sda = 1'b1;
                    end else begin
                        scl = (sub == 2'd1);
                    end
                end
            endcase
        endfunction

        function void open_segment(logic [3:0] pos);
            t_kind kind;
            kind    = segment_kind(cur_op, pos);
            bit_idx = 3'd0;
            case (kind)
                K_ADDR_W: shifter = {dev_addr, 1'b0};
                K_ADDR_R: shifter = {dev_addr, 1'b1};
                K_REG:    shifter = reg_byte;
                K_DATA:   shifter = data_byte;
                K_RECV:   shifter = 8'd0;
                default:  ;
            endcase
            seq_step = {pos, 2'd0};
            drive_line(kind, 2'd0);
        endfunction

        function void close_bus();
            seq_step = 6'd0;
            bit_idx  = 3'd0;
            scl      = 1'b1;
            sda      = 1'b1;
        endfunction

        // end of one line step; returns 1 when the transfer is over
        function bit step_done(logic sda_line);
            logic [3:0] pos;
            logic [1:0] sub;
            logic [1:0] nxt;
            t_kind      kind;
            bit         last;
            pos  = seq_step[5:2];
            sub  = seq_step[1:0];
            last = 1'b0;
            if (pos == 4'd0 || pos > seg_count(cur_op)) begin
                close_bus();
                return 1'b1;
            end
            kind = segment_kind(cur_op, pos);
            // sampling happens at the end of the SCL-high step
            if (sub == 2'd1 && kind == K_ACK && sda_line) nack_seen = 1'b1;
            if (sub == 2'd1 && kind == K_RECV) shifter = {shifter[6:0], sda_line};
            nxt = sub + 2'd1;
            case (kind)
                K_START: last = (sub == 2'd3);
                K_ADDR_W, K_ADDR_R, K_REG, K_DATA: begin
                    if (sub >= 2'd2) begin
                        if (bit_idx == 3'd7) begin
                            last = 1'b1;
                        end else begin
                            bit_idx = bit_idx + 3'd1;
                            shifter = {shifter[6:0], 1'b0};
                            nxt     = 2'd0;
                        end
                    end
                end
                K_RECV: begin
                    if (sub >= 2'd2) begin
                        if (bit_idx == 3'd7) begin
                            last = 1'b1;
                        end else begin
                            bit_idx = bit_idx + 3'd1;
                            nxt     = 2'd1;
                        end
                    end
                end
                default: last = (sub >= 2'd2);
            endcase
            if (!last) begin
                seq_step = {pos, nxt};
                drive_line(kind, nxt);
                return 1'b0;
            end
            if (kind == K_RECV) rx_byte = shifter;
            if (pos + 1 > seg_count(cur_op)) begin
                close_bus();
                return 1'b1;
            end
            open_segment(pos + 4'd1);
            return 1'b0;
        endfunction

        // one accepted tick: advance the sequencer and queue the line sample
        function void note_tick(logic [1:0] op, logic [7:0] reg_in, logic [7:0] data_in,
                                logic sda_line);
            logic        busy;
            logic        done;
            logic [15:0] limit;
            t_bus_sample smp;
            busy  = 1'b0;
            done  = 1'b0;
            limit = (step_len == 16'd0) ? 16'd1 : step_len;
            if (seq_step == 6'd0) begin
                if (op != OP_TICK) begin
                    cur_op    = op;
                    reg_byte  = reg_in;
                    data_byte = data_in;
                    nack_seen = 1'b0;
                    tick_cnt  = 16'd0;
                    open_segment(4'd1);
                    busy      = 1'b1;
                end
            end else begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= limit) begin
                    tick_cnt = 16'd0;
                    done     = step_done(sda_line);
                end
                busy = !done;
            end
            smp = {scl, sda, busy, done, rx_byte, nack_seen};
            expected_lines.push_back(smp);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_bus_sample got);
            t_bus_sample want;
            if (expected_lines.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = expected_lines.pop_front();
            compare("scl_out", want.scl, got.scl);
            compare("sda_out", want.sda, got.sda);
            compare("busy_res", want.busy, got.busy);
            compare("done_res", want.done, got.done);
            compare("read_byte", want.rd_byte, got.rd_byte);
            compare("nack", want.nack, got.nack);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known level
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode      = OP_TICK;
    logic [7:0]  i_reg_address = 8'd0;
    logic [7:0]  i_write_data  = 8'd0;
    logic        i_sda_in      = 1'b1;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_scl_out;
    logic        o_sda_out;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_read_byte;
    logic        o_nack;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = CFG_DEVICE_ADDRESS;
    logic [15:0] i_cfg_data    = 16'd0;

    bus_tick_scoreboard sb;

    // idling knobs, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // long hold-off requests: main bumps hold_asked, the sink process serves it
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;

    i2c_master_register_access dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_reg_address (i_reg_address),
        .i_write_data  (i_write_data),
        .i_sda_in      (i_sda_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scl_out     (o_scl_out),
        .o_sda_out     (o_sda_out),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_read_byte   (o_read_byte),
        .o_nack        (o_nack),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stall, or a long hold-off counted here in cycles so the
    // single result slot fills and the block has to stall its input.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Both handshakes sampled at the rising edge, before the DUT's registers move.
    always @(posedge i_clk) begin : monitor
        t_bus_sample seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen = {o_scl_out, o_sda_out, o_busy_res, o_done_res, o_read_byte, o_nack};
                sb.check_result(seen);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_tick(i_opcode, i_reg_address, i_write_data, i_sda_in);
            end
        end
    end

    function automatic logic pick_sda(int mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    // One tick transaction. Starts and ends just after a falling edge; valid is
    // left high so back-to-back ticks need no extra assignment.
    task automatic send_tick(input logic [1:0] op, input logic [7:0] reg_in,
                             input logic [7:0] data_in, input logic sda_line);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_reg_address <= reg_in;
        i_write_data  <= data_in;
        i_sda_in      <= sda_line;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic pause_input();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Keep ticking until the predicted bus is idle again; opcodes here are random,
    // so the ones landing mid-transfer and on the done tick must be ignored.
    task automatic finish_transfer(input int sda_mode);
        while (sb.bus_active()) begin
            send_tick(2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), pick_sda(sda_mode));
        end
        pause_input();
    endtask

    task automatic run_transfer(input logic [1:0] op, input logic [7:0] reg_in,
                                input logic [7:0] data_in, input int sda_mode);
        send_tick(op, reg_in, data_in, pick_sda(sda_mode));
        finish_transfer(sda_mode);
    endtask

    // Random traffic: mostly real operations so the idle slots start new transfers.
    task automatic run_traffic(input int n_items);
        logic [1:0] op;
        for (int k = 0; k < n_items; k++) begin
            op = ($urandom_range(99) < 80) ? 2'($urandom_range(3, 1)) : OP_TICK;
            send_tick(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        end
        pause_input();
    endtask

    // every outstanding result back, then let the registered result output drain
    task automatic wait_results();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_cfg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input logic [15:0] addr,
                             input logic [15:0] step, input int n_items, input bit squeeze);
        wait_results();
        write_cfg(CFG_DEVICE_ADDRESS, addr);
        write_cfg(CFG_STEP_TICKS, step);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if (squeeze) hold_asked++;
        run_traffic(n_items);
        finish_transfer(SDA_RANDOM);
    endtask

    // Run guard, far above the slowest legal run.
    initial begin
        #10_000_000;
        $display("i2c_master_register_access test failed");
        $finish;
    end

    initial begin
        sb = new;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: address 127 given with junk in the upper data bits, fastest bus.
        write_cfg(CFG_DEVICE_ADDRESS, 16'hFFFF);
        write_cfg(CFG_STEP_TICKS, 16'd1);
        run_transfer(OP_WRITE, 8'hFF, 8'h00, SDA_LOW);    // all acks good
        run_transfer(OP_WRITE, 8'h00, 8'hFF, SDA_HIGH);   // every ack missing
        run_transfer(OP_READ, 8'hA5, 8'h3C, SDA_HIGH);    // reads 0xFF, nack set
        run_transfer(OP_READ, 8'h5A, 8'hC3, SDA_LOW);     // reads 0x00, nack clear
        run_transfer(OP_PROBE, 8'h00, 8'h00, SDA_LOW);    // device present
        run_transfer(OP_PROBE, 8'hFF, 8'hFF, SDA_HIGH);   // nobody home
        send_tick(OP_TICK, 8'hFF, 8'hFF, 1'b1);           // plain tick while idle
        pause_input();

        // Address zero and a zero step length, which the block runs as one tick.
        wait_results();
        write_cfg(CFG_DEVICE_ADDRESS, 16'd0);
        write_cfg(CFG_STEP_TICKS, 16'd0);
        run_transfer(OP_READ, 8'h81, 8'h7E, SDA_RANDOM);
        run_transfer(OP_WRITE, 8'h7E, 8'h81, SDA_RANDOM);

        // Longest step: the tick counter is still running in the first step when
        // the step is cut back mid-transfer, which must take effect at once.
        wait_results();
        write_cfg(CFG_STEP_TICKS, 16'hFFFF);
        send_tick(OP_PROBE, 8'h3C, 8'hC3, 1'b0);
        for (int k = 0; k < 40; k++) begin
            send_tick(2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        pause_input();
        wait_results();
        write_cfg(CFG_STEP_TICKS, 16'd1);
        finish_transfer(SDA_RANDOM);

        // Random traffic under each idling mix, first one with the long hold-off.
        run_phase(0, 0, 16'h0055, 16'd2, 250, 1'b1);
        run_phase(81, 0, 16'h002A, 16'd1, 200, 1'b0);
        run_phase(0, 81, 16'h007F, 16'd3, 200, 1'b0);
        run_phase(33, 33, 16'h0000, 16'd1, 200, 1'b0);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int waited = 0; waited < 20000 && sb.pending() != 0; waited++) begin
            @(posedge i_clk);
        end
        if (sb.pending() != 0) begin
            $error("%0d result transactions never arrived", sb.pending());
            sb.errors++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("i2c_master_register_access test passed");
        end else begin
            $display("i2c_master_register_access test failed");
        end
        $finish;
    end

endmodule
